// ===== rtl/sitbd_pkg.sv =====
// ----------------------------------------------------------------------------
// sitbd_pkg
// Shared constants, types and register codes for the integer-to-text block.
// ----------------------------------------------------------------------------
package sitbd_pkg;

  localparam int NumW     = 32;              // input number width
  localparam int CharW    = 8;               // one character byte
  localparam int LenW     = 5;               // base_length register width
  localparam int CfgW     = 64;              // config data width
  localparam int NumSym   = 16;              // symbols held by the two table registers
  localparam int DigW     = $clog2(NumSym);  // digit value width
  localparam int MaxBase  = 16;              // longest usable base
  localparam int StackDep = NumW;            // most digits a magnitude can have
  localparam int StackAw  = $clog2(StackDep);
  localparam int NdigW    = StackAw + 1;
  localparam int BitsPerStep = 8;            // dividend bits retired per divider cycle
  localparam int DivSteps = NumW / BitsPerStep;
  localparam int StepW    = $clog2(DivSteps);
  localparam int AddrW    = 5;

  localparam logic [CharW-1:0] CharMinus = 8'h2D;
  localparam logic [CharW-1:0] CharPlus  = 8'h2B;

  // register index codes, taken from paddr[4:3]
  localparam logic [1:0] RegBaseLen = 2'd0;
  localparam logic [1:0] RegCharsLo = 2'd1;
  localparam logic [1:0] RegCharsHi = 2'd2;

  localparam logic [LenW-1:0] BaseLenRst  = 5'd10;
  localparam logic [CfgW-1:0] CharsLoRst  = 64'h3736353433323130;
  localparam logic [CfgW-1:0] CharsHiRst  = 64'h0000000000003938;

  typedef struct packed {
    logic            load;       // capture a new number
    logic            chk;        // check one symbol of the base
    logic [DigW-1:0] chk_idx;
    logic            div;        // one divider step
    logic            push;       // store finished digit
    logic            emit_sign;  // put '-' in the output register
    logic            pop;        // put the top digit's symbol in the output register
  } sitbd_cmd_t;

  typedef struct packed {
    logic base_ok;
    logic quo_zero;
    logic ndig_zero;
    logic ndig_one;
    logic neg;
    logic out_free;
  } sitbd_sts_t;

endpackage

// ===== rtl/sitbd_cfg.sv =====
// ----------------------------------------------------------------------------
// sitbd_cfg
// APB register file: base length and the two digit symbol tables.
// ----------------------------------------------------------------------------
module sitbd_cfg import sitbd_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [AddrW-1:0] paddr,
  input  logic [CfgW-1:0]  pwdata,
  output logic [CfgW-1:0]  prdata,
  output logic             pready,
  output logic [LenW-1:0]  base_len_o,
  output logic [CfgW-1:0]  chars_lo_o,
  output logic [CfgW-1:0]  chars_hi_o
);

  logic [LenW-1:0] base_len_q;
  logic [CfgW-1:0] chars_lo_q, chars_hi_q;
  logic            wr_en;
  logic [1:0]      reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:3];
  assign wr_en   = psel & penable & pwrite & pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_len_q <= BaseLenRst;
      chars_lo_q <= CharsLoRst;
      chars_hi_q <= CharsHiRst;
    end else if (wr_en) begin
      case (reg_idx)
        RegBaseLen: base_len_q <= pwdata[LenW-1:0];
        RegCharsLo: chars_lo_q <= pwdata;
        RegCharsHi: chars_hi_q <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      RegBaseLen: prdata = {{(CfgW-LenW){1'b0}}, base_len_q};
      RegCharsLo: prdata = chars_lo_q;
      RegCharsHi: prdata = chars_hi_q;
      default:    prdata = '0;
    endcase
  end

  assign base_len_o = base_len_q;
  assign chars_lo_o = chars_lo_q;
  assign chars_hi_o = chars_hi_q;

endmodule

// ===== rtl/sitbd_dp.sv =====
// ----------------------------------------------------------------------------
// sitbd_dp
// Datapath: base check, byte-wide radix divider, digit stack, output register.
// ----------------------------------------------------------------------------
module sitbd_dp import sitbd_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [NumW-1:0]  number_i,
  input  logic [LenW-1:0]  base_len_i,
  input  logic [CfgW-1:0]  chars_lo_i,
  input  logic [CfgW-1:0]  chars_hi_i,
  input  sitbd_cmd_t       cmd_i,
  output sitbd_sts_t       sts_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [CharW-1:0] out_char_o,
  output logic             out_last_o
);

  logic [CharW-1:0] sym [NumSym];
  logic [2*CfgW-1:0] sym_all;

  logic [NumW-1:0]  div_q, div_d;
  logic [DigW-1:0]  rem_q, rem_d;
  logic [NdigW-1:0] ndig_q;
  logic [StackAw-1:0] rd_idx;
  logic             bad_q, neg_q, bad_now;
  logic [DigW-1:0]  stack_q [StackDep];
  logic             out_valid_q, out_last_q;
  logic [CharW-1:0] out_char_q;
  logic             out_free;

  assign sym_all = {chars_hi_i, chars_lo_i};

  always_comb begin
    for (int k = 0; k < NumSym; k++) begin
      sym[k] = sym_all[CharW*k +: CharW];
    end
  end

  // one symbol against '+', '-' and every later symbol in use
  always_comb begin
    logic [CharW-1:0] cur;
    logic             hit;
    logic             in_use;
    cur    = sym[cmd_i.chk_idx];
    hit    = 1'b0;
    in_use = {1'b0, cmd_i.chk_idx} < base_len_i;
    for (int j = 0; j < NumSym; j++) begin
      if (DigW'(j) > cmd_i.chk_idx && LenW'(j) < base_len_i && sym[j] == cur) begin
        hit = 1'b1;
      end
    end
    bad_now = in_use && (cur == CharPlus || cur == CharMinus || hit);
  end

  // restoring division, one byte of the dividend per cycle
  always_comb begin
    logic [DigW:0]          t;
    logic [BitsPerStep-1:0] qb;
    t  = '0;
    qb = '0;
    rem_d = rem_q;
    for (int b = 0; b < BitsPerStep; b++) begin
      t = {rem_d, div_q[NumW-1-b]};
      if (t >= base_len_i) begin
        t = t - base_len_i;
        qb[BitsPerStep-1-b] = 1'b1;
      end
      rem_d = t[DigW-1:0];
    end
    div_d = {div_q[NumW-BitsPerStep-1:0], qb};
  end

  assign rd_idx = StackAw'(ndig_q - NdigW'(1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ndig_q <= '0;
      bad_q  <= 1'b0;
      neg_q  <= 1'b0;
    end else begin
      if (cmd_i.load) begin
        ndig_q <= '0;
        bad_q  <= 1'b0;
        neg_q  <= number_i[NumW-1];
      end else if (cmd_i.push) begin
        ndig_q <= ndig_q + NdigW'(1);
      end else if (cmd_i.pop) begin
        ndig_q <= ndig_q - NdigW'(1);
      end
      if (cmd_i.chk && bad_now) bad_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      div_q <= number_i[NumW-1] ? (NumW'(0) - number_i) : number_i;
      rem_q <= '0;
    end else if (cmd_i.div) begin
      div_q <= div_d;
      rem_q <= rem_d;
    end else if (cmd_i.push) begin
      rem_q <= '0;
    end
    if (cmd_i.push) stack_q[ndig_q[StackAw-1:0]] <= rem_q;
  end

  // output register
  assign out_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit_sign || cmd_i.pop) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit_sign) begin
      out_char_q <= CharMinus;
      out_last_q <= (ndig_q == '0);
    end else if (cmd_i.pop) begin
      out_char_q <= sym[stack_q[rd_idx]];
      out_last_q <= (ndig_q == NdigW'(1));
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_char_o  = out_char_q;
  assign out_last_o  = out_last_q;

  always_comb begin
    sts_o.base_ok   = !bad_q && base_len_i >= LenW'(2) && base_len_i <= LenW'(MaxBase);
    sts_o.quo_zero  = (div_q == '0);
    sts_o.ndig_zero = (ndig_q == '0);
    sts_o.ndig_one  = (ndig_q == NdigW'(1));
    sts_o.neg       = neg_q;
    sts_o.out_free  = out_free;
  end

endmodule

// ===== rtl/sitbd_ctrl.sv =====
// ----------------------------------------------------------------------------
// sitbd_ctrl
// Sequencer: base check sweep, digit division loop, sign and digit output.
// ----------------------------------------------------------------------------
module sitbd_ctrl import sitbd_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  sitbd_sts_t sts_i,
  output sitbd_cmd_t cmd_o
);

  localparam logic [2:0] SIdle   = 3'd0;
  localparam logic [2:0] SCheck  = 3'd1;
  localparam logic [2:0] SDecide = 3'd2;
  localparam logic [2:0] SDiv    = 3'd3;
  localparam logic [2:0] SPush   = 3'd4;
  localparam logic [2:0] SSign   = 3'd5;
  localparam logic [2:0] SEmit   = 3'd6;

  logic [2:0]       state_q, state_d;
  logic [DigW-1:0]  idx_q, idx_d;
  logic [StepW-1:0] step_q, step_d;

  assign in_ready_o = (state_q == SIdle);

  always_comb begin
    state_d = state_q;
    idx_d   = idx_q;
    step_d  = step_q;
    cmd_o   = '0;
    cmd_o.chk_idx = idx_q;
    case (state_q)
      SIdle: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          idx_d      = '0;
          state_d    = SCheck;
        end
      end
      SCheck: begin
        cmd_o.chk = 1'b1;
        idx_d     = idx_q + DigW'(1);
        if (idx_q == DigW'(NumSym - 1)) state_d = SDecide;
      end
      SDecide: begin
        step_d = '0;
        if (sts_i.base_ok) state_d = SDiv;
        else if (sts_i.neg) state_d = SSign;
        else state_d = SIdle;
      end
      SDiv: begin
        cmd_o.div = 1'b1;
        step_d    = step_q + StepW'(1);
        if (step_q == StepW'(DivSteps - 1)) state_d = SPush;
      end
      SPush: begin
        cmd_o.push = 1'b1;
        step_d     = '0;
        if (!sts_i.quo_zero) state_d = SDiv;
        else if (sts_i.neg) state_d = SSign;
        else state_d = SEmit;
      end
      SSign: begin
        if (sts_i.out_free) begin
          cmd_o.emit_sign = 1'b1;
          state_d = sts_i.ndig_zero ? SIdle : SEmit;
        end
      end
      SEmit: begin
        if (sts_i.out_free) begin
          cmd_o.pop = 1'b1;
          if (sts_i.ndig_one) state_d = SIdle;
        end
      end
      default: state_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
      idx_q   <= '0;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      step_q  <= step_d;
    end
  end

endmodule

// ===== rtl/signed_int_to_base_digits.sv =====
// ----------------------------------------------------------------------------
// signed_int_to_base_digits
// Renders a signed 32-bit number as text in a programmable base.
// ----------------------------------------------------------------------------
// One number is taken at a time. After acceptance the block checks the base
// symbols (one symbol against all later ones per cycle), then decides, then
// runs the divider for each digit (it retires one byte of the dividend per
// cycle, then the digit is stacked), then emits a '-' for a negative number
// and the output characters one at a time, holding while the output stalls.
// With an invalid base only a '-' beat (negative input) or nothing appears.
module signed_int_to_base_digits import sitbd_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  input  logic [NumW-1:0]  s_axis_tdata,   // [31:0] number
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  output logic [CharW-1:0] m_axis_tdata,   // [7:0] out_char
  output logic             m_axis_tlast,   // last_char
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [AddrW-1:0] paddr,
  input  logic [CfgW-1:0]  pwdata,
  output logic [CfgW-1:0]  prdata,
  output logic             pready
);

  logic [LenW-1:0] base_len;
  logic [CfgW-1:0] chars_lo, chars_hi;
  sitbd_cmd_t      cmd;
  sitbd_sts_t      sts;

  sitbd_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .base_len_o (base_len),
    .chars_lo_o (chars_lo),
    .chars_hi_o (chars_hi)
  );

  sitbd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  sitbd_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .number_i    (s_axis_tdata),
    .base_len_i  (base_len),
    .chars_lo_i  (chars_lo),
    .chars_hi_i  (chars_hi),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_char_o  (m_axis_tdata),
    .out_last_o  (m_axis_tlast)
  );

endmodule

// ===== rtl/sitbd_chk.sv =====
// ----------------------------------------------------------------------------
// sitbd_chk
// Port-level checks for the integer-to-text block, bound to the top level.
// ----------------------------------------------------------------------------
module sitbd_chk import sitbd_pkg::*; (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             s_axis_tvalid,
  input logic             s_axis_tready,
  input logic             m_axis_tvalid,
  input logic             m_axis_tready,
  input logic [CharW-1:0] m_axis_tdata,
  input logic             m_axis_tlast,
  input logic             pready
);

  // a stalled output beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("output beat changed while stalled");

  // one number at a time: input closes right after a beat is taken
  a_in_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input ready right after accepting a number");

  // the base check sweep keeps the output quiet well after an accept
  a_no_early_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && !m_axis_tvalid |=> ##8 !m_axis_tvalid)
    else $error("output beat before base check finished");

  a_pready: assert property (@(posedge clk_i) disable iff (!rst_ni) pready)
    else $error("pready low");

endmodule

bind signed_int_to_base_digits sitbd_chk u_sitbd_chk (.*);
